// ----- hdl/sip_pkg.sv -----
// Shared constants, types and the stencil table of the Simpson integrator.
package sip_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_SAMPLES = 65535;
  localparam int CNT_W       = 17;
  localparam int WIN_DEPTH   = 6;
  localparam int STEN_W      = 40;    // signed stencil sum, |s| <= 160 * 2^31
  localparam int MFD_W       = 39;    // magnitude of the stencil sum
  localparam int N1_W        = 16;    // sample count less one
  localparam int WIDE_W      = 528;   // holds X = (D^5 m)^2 (2^64 + h^4) < 2^527
  localparam int WCNT_W      = $clog2(WIDE_W);
  localparam int ERR_K       = 1080;  // 180 times the stencil's 6
  localparam logic [63:0] SAT_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_EVEN = 2'd1,
    ST_FEW  = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ERR_ZERO,
    ERR_SAT,
    ERR_CALC
  } err_mode_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_STEN,
    F_UPD,
    F_FIN,
    F_CALC,
    F_DONE
  } front_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_LOAD,
    E_MUL,
    E_SQRT,
    E_DIV,
    E_WB
  } eng_state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } op_kind_t;

  // engine program, run in this order
  typedef enum logic [4:0] {
    ST_IPROD,
    ST_IDIV,
    ST_D2,
    ST_D4,
    ST_D5,
    ST_P,
    ST_P2,
    ST_H2,
    ST_H4,
    ST_X,
    ST_ROOT,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_N4,
    ST_K,
    ST_EDIV
  } step_t;

  typedef struct packed {
    logic             start;
    err_mode_t        mode;
    logic             neg;
    logic [31:0]      dmag;
    logic [63:0]      wmag;
    logic [N1_W-1:0]  n1;
    logic [MFD_W-1:0] m;
    logic [31:0]      h;
  } eng_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] integral;
    logic [63:0] error;
  } eng_rsp_t;

  function automatic logic signed [7:0] stencil_coef(input logic [2:0] tap);
    logic signed [7:0] c;
    case (tap)
      3'd0, 3'd6: c = -8'sd1;
      3'd1, 3'd5: c = 8'sd12;
      3'd2, 3'd4: c = -8'sd39;
      3'd3:       c = 8'sd56;
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/sip_engine.sv -----
// Wide shift-add engine: products, integer root and capped divisions of one set.
module sip_engine
  import sip_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  eng_req_t req,
  output eng_rsp_t rsp
);

  eng_state_t          state, state_next;
  step_t               pc, pc_next;
  op_kind_t            kind;
  logic                dst_t1;
  logic                last_step;
  logic                done;
  logic [WIDE_W-1:0]   ma, mb, acc, t0, t1;
  logic [WIDE_W-1:0]   opa, opb, rem1, rem2, trial;
  logic                sub;
  logic [WIDE_W:0]     sum;
  logic                ge;
  logic [63:0]         q, cap, capped;
  logic                qbig;
  logic [WCNT_W-1:0]   cnt;
  err_mode_t           mode;
  logic                neg;
  logic [31:0]         dmag, h;
  logic [63:0]         wmag;
  logic [N1_W-1:0]     n1;
  logic [N1_W+1:0]     n1x3;
  logic [MFD_W-1:0]    m;
  logic [63:0]         integ, err;

  // step decode
  always_comb begin
    case (pc)
      ST_IDIV, ST_EDIV: kind = OP_DIV;
      ST_ROOT:          kind = OP_SQRT;
      default:          kind = OP_MUL;
    endcase
    case (pc)
      ST_H2, ST_H4, ST_N1, ST_N2, ST_N3, ST_N4, ST_K: dst_t1 = 1'b1;
      default:                                        dst_t1 = 1'b0;
    endcase
    last_step = ((pc == ST_IDIV) && (mode != ERR_CALC)) || (pc == ST_EDIV);
  end

  // the one shared adder
  always_comb begin
    rem1  = {acc[WIDE_W-2:0], ma[WIDE_W-1]};
    rem2  = {acc[WIDE_W-3:0], ma[WIDE_W-1:WIDE_W-2]};
    trial = {mb[WIDE_W-3:0], 2'b01};
    case (state)
      E_SQRT: begin
        opa = rem2;
        opb = trial;
        sub = 1'b1;
      end
      E_DIV: begin
        opa = rem1;
        opb = mb;
        sub = 1'b1;
      end
      default: begin
        opa = acc;
        opb = ma;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (WIDE_W + 1)'(sub);
    ge  = sum[WIDE_W];
  end

  always_comb begin
    n1x3   = (N1_W + 2)'(n1) + (N1_W + 2)'({n1, 1'b0});
    cap    = ((pc == ST_IDIV) && neg) ? SAT_NEG : SAT_POS;
    capped = (qbig || (q > cap)) ? cap : q;
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      E_IDLE: begin
        if (req.start) begin
          state_next = E_LOAD;
          pc_next    = ST_IPROD;
        end
      end
      E_LOAD: begin
        case (kind)
          OP_MUL:  state_next = E_MUL;
          OP_SQRT: state_next = E_SQRT;
          default: state_next = E_DIV;
        endcase
      end
      E_MUL: begin
        if (mb == '0) state_next = E_WB;
      end
      E_SQRT, E_DIV: begin
        if (cnt == '0) state_next = E_WB;
      end
      E_WB: begin
        if (last_step) begin
          state_next = E_IDLE;
        end else begin
          state_next = E_LOAD;
          pc_next    = step_t'(pc + 5'd1);
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      pc    <= ST_IPROD;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      done  <= (state == E_WB) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (req.start) begin
          mode <= req.mode;
          neg  <= req.neg;
          dmag <= req.dmag;
          wmag <= req.wmag;
          n1   <= req.n1;
          m    <= req.m;
          h    <= req.h;
        end
      end
      E_LOAD: begin
        acc  <= (pc == ST_X) ? (t0 << (4 * FRAC_BITS)) : '0;
        q    <= '0;
        qbig <= 1'b0;
        cnt  <= (pc == ST_ROOT) ? WCNT_W'(WIDE_W / 2 - 1) : WCNT_W'(WIDE_W - 1);
        case (pc)
          ST_IPROD: begin
            ma <= WIDE_W'(wmag);
            mb <= WIDE_W'(dmag);
          end
          ST_IDIV: begin
            ma <= t0;
            mb <= WIDE_W'(n1x3) << FRAC_BITS;
          end
          ST_D2: begin
            ma <= WIDE_W'(dmag);
            mb <= WIDE_W'(dmag);
          end
          ST_D4, ST_P2: begin
            ma <= t0;
            mb <= t0;
          end
          ST_D5: begin
            ma <= t0;
            mb <= WIDE_W'(dmag);
          end
          ST_P: begin
            ma <= t0;
            mb <= WIDE_W'(m);
          end
          ST_H2: begin
            ma <= WIDE_W'(h);
            mb <= WIDE_W'(h);
          end
          ST_H4: begin
            ma <= t1;
            mb <= t1;
          end
          ST_X: begin
            // P^2 h^4 + P^2 2^64 in one pass
            ma <= t0;
            mb <= t1;
          end
          ST_ROOT: begin
            ma <= t0;
            mb <= '0;
          end
          ST_N1, ST_N2, ST_N3, ST_N4: begin
            ma <= t1;
            mb <= WIDE_W'(n1);
          end
          ST_K: begin
            ma <= t1;
            mb <= WIDE_W'(ERR_K);
          end
          ST_EDIV: begin
            // the 2^48 of the divisor comes off the dividend
            ma <= t0 >> (3 * FRAC_BITS);
            mb <= t1;
          end
          default: begin
            ma <= '0;
            mb <= '0;
          end
        endcase
      end
      E_MUL: begin
        if (mb != '0) begin
          if (mb[0]) acc <= sum[WIDE_W-1:0];
          ma <= ma << 1;
          mb <= mb >> 1;
        end
      end
      E_SQRT: begin
        ma  <= ma << 2;
        cnt <= cnt - 1'b1;
        if (ge) begin
          acc <= sum[WIDE_W-1:0];
          mb  <= {mb[WIDE_W-2:0], 1'b1};
        end else begin
          acc <= rem2;
          mb  <= {mb[WIDE_W-2:0], 1'b0};
        end
      end
      E_DIV: begin
        ma   <= ma << 1;
        cnt  <= cnt - 1'b1;
        acc  <= ge ? sum[WIDE_W-1:0] : rem1;
        q    <= {q[62:0], ge};
        qbig <= qbig | q[63];
      end
      E_WB: begin
        case (kind)
          OP_MUL: begin
            if (dst_t1) t1 <= acc;
            else t0 <= acc;
          end
          OP_SQRT: t0 <= mb;
          default: begin
            if (pc == ST_IDIV) begin
              integ <= neg ? (64'd0 - capped) : capped;
              err   <= (mode == ERR_SAT) ? SAT_POS : '0;
            end else begin
              err <= capped;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.busy     = (state != E_IDLE);
  assign rsp.done     = done;
  assign rsp.integral = integ;
  assign rsp.error    = err;

endmodule

// ----- hdl/simpson_integrator_with_error.sv -----
// A sample is accepted, passed through 7 stencil taps on one small multiplier, then used for the update.
// A last sample adds the wide engine, whose run is set by its single 528-bit adder
// (528-step divisions, a 264-step root, shift-add products at one multiplier bit a cycle);
// the error term adds steps to that run. Throughput: one sample at a time.
// Reset: synchronous, active high; clears the window, sums, count and handshake state.
module simpson_integrator_with_error
  import sip_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_sample,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] integral,
  output logic [62:0]        error_estimate,
  output logic [1:0]         status
);

  front_state_t       state, state_next;
  logic signed [31:0] win [WIN_DEPTH];
  logic signed [63:0] wsum;
  logic [MFD_W-1:0]   mfd;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] first_x, second_x;
  logic               ovf;

  // the beat under work
  logic signed [31:0] x_in, y_in;
  logic               last_in;
  logic [2:0]         tap;
  logic signed [STEN_W-1:0] s_acc, tap_prod;
  logic signed [31:0] tap_val;
  logic [MFD_W-1:0]   s_abs;
  logic signed [63:0] wterm;

  status_t            set_status, fin_status;
  logic signed [32:0] span, stride;
  logic [31:0]        span_mag, stride_mag;
  logic [63:0]        wmag;
  logic               accept, out_free;
  eng_req_t           eng_req;
  eng_rsp_t           eng_rsp;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // one stencil tap a cycle; tap six is the new sample itself
  always_comb begin
    tap_val  = (tap == 3'(WIN_DEPTH)) ? y_in : win[tap];
    tap_prod = STEN_W'(tap_val) * STEN_W'(stencil_coef(tap));
    s_abs    = s_acc[STEN_W-1] ? MFD_W'(-s_acc) : MFD_W'(s_acc);
  end

  // Simpson weights: 1 at the ends, then 4, 2, 4, ...
  always_comb begin
    if ((count == '0) || last_in) wterm = 64'(y_in);
    else if (count[0]) wterm = 64'(y_in) <<< 2;
    else wterm = 64'(y_in) <<< 1;
  end

  // figures for the end of a set
  always_comb begin
    span       = 33'(x_in) - 33'(first_x);
    stride     = 33'(second_x) - 33'(first_x);
    span_mag   = span[32] ? 32'(-span) : 32'(span);
    stride_mag = stride[32] ? 32'(-stride) : 32'(stride);
    wmag       = wsum[63] ? (64'd0 - wsum) : wsum;

    if (ovf) fin_status = ST_OVF;
    else if (count < CNT_W'(3)) fin_status = ST_FEW;
    else if (!count[0]) fin_status = ST_EVEN;
    else fin_status = ST_OK;

    eng_req.start = (state == F_FIN) && (fin_status == ST_OK);
    eng_req.neg   = (span[32] != wsum[63]) && (span != '0) && (wsum != '0);
    eng_req.dmag  = span_mag;
    eng_req.wmag  = wmag;
    eng_req.n1    = N1_W'(count - 1'b1);
    eng_req.m     = mfd;
    eng_req.h     = stride_mag;
    // error is nil below seven samples or with no span or no curvature;
    // a zero step divides by zero and saturates
    if ((count < CNT_W'(7)) || (span_mag == '0) || (mfd == '0)) eng_req.mode = ERR_ZERO;
    else if (stride_mag == '0) eng_req.mode = ERR_SAT;
    else eng_req.mode = ERR_CALC;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_STEN;
      F_STEN: if (tap == 3'(WIN_DEPTH)) state_next = F_UPD;
      F_UPD:  state_next = last_in ? F_FIN : F_IDLE;
      F_FIN:  state_next = (fin_status == ST_OK) ? F_CALC : F_DONE;
      F_CALC: if (eng_rsp.done) state_next = F_DONE;
      F_DONE: if (out_free) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // running set state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] <= '0;
      wsum       <= '0;
      mfd        <= '0;
      count      <= '0;
      first_x    <= '0;
      second_x   <= '0;
      ovf        <= 1'b0;
      tap        <= '0;
      set_status <= ST_OK;
    end else begin
      case (state)
        F_IDLE: if (accept) tap <= '0;
        F_STEN: tap <= tap + 1'b1;
        F_UPD: begin
          if (!ovf) begin
            if (count >= CNT_W'(MAX_SAMPLES)) begin
              // sample dropped, set ends with an overflow status
              ovf <= 1'b1;
            end else begin
              if (count == CNT_W'(0)) first_x <= x_in;
              if (count == CNT_W'(1)) second_x <= x_in;
              wsum <= wsum + wterm;
              if ((count >= CNT_W'(WIN_DEPTH)) && (s_abs > mfd)) mfd <= s_abs;
              for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] <= win[i+1];
              win[WIN_DEPTH-1] <= y_in;
              count <= count + 1'b1;
            end
          end
        end
        F_FIN: begin
          // an engine start latches its operands on this edge; start afresh
          set_status <= fin_status;
          for (int i = 0; i < WIN_DEPTH; i++) win[i] <= '0;
          wsum     <= '0;
          mfd      <= '0;
          count    <= '0;
          first_x  <= '0;
          second_x <= '0;
          ovf      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_in    <= x_coord;
      y_in    <= y_sample;
      last_in <= last;
      s_acc   <= '0;
    end else if (state == F_STEN) begin
      s_acc <= s_acc + tap_prod;
    end
  end

  // output register: frees the sample side while a result beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == F_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == F_DONE) && out_free) begin
      integral       <= (set_status == ST_OK) ? eng_rsp.integral : '0;
      error_estimate <= (set_status == ST_OK) ? eng_rsp.error[62:0] : '0;
      status         <= set_status;
    end
  end

  sip_engine u_engine (
    .clk (clk),
    .rst (rst),
    .req (eng_req),
    .rsp (eng_rsp)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("sample side not busy after accepting a beat");

  a_fault_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (integral == '0) && (error_estimate == '0))
    else $error("nonzero result with a fault status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond its limit");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    eng_req.start |-> !eng_rsp.busy)
    else $error("engine started while busy");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    eng_rsp.done |-> (state == F_CALC))
    else $error("engine finished with nobody waiting");
`endif

endmodule
